// ===== rtl/mm4_pkg.sv =====
// Shared types and constants for the 4x4 matrix multiplier.
`timescale 1ns / 1ps
`default_nettype none
package mm4_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 64;
  localparam int FRAC_W    = 16;
  localparam int IDX_MAX_W = 4;
  localparam int OUT_IDX_W = 2;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // Token that walks the cell chain, one per result entry.
  typedef struct packed {
    logic                 valid;
    logic [IDX_MAX_W-1:0] row;
    logic [IDX_MAX_W-1:0] col;
    logic                 last;
  } tok_t;

endpackage
`default_nettype wire

// ===== rtl/matrix_multiply_4x4.sv =====
// Top level of the matrix multiplier: load sequencing, cell chain, saturation and output stage.
//
// Usage:
//   in_entry takes 2*DIM*DIM signed Q16.16 entries with valid/ready: the first
//   matrix row-major, then the second matrix row-major. Loading takes one item
//   per cycle. The item that completes the second matrix starts the job, which
//   emits second x first as DIM*DIM items on the out_ channel, row-major, with
//   out_row/out_col and out_last on the final entry.
//   Each result is streamed through a chain of DIM MAC cells; cell k adds
//   second[i][k]*first[k][j] to the running sum (two registers per cell), so
//   the first result passes the issue register, the cell registers and the
//   output register after the last load, then one result per cycle unless
//   out_ready stalls. The length of a job of 32 items is set by the
//   single-ported load path and the one-token-per-cycle issue into the chain.
//   in_ready stays low from the completing item until the last result is taken.
//   A stall on out_ready freezes the whole chain; nothing is lost.
//   Reset (rst_n low, synchronous) clears the load counters and the pipeline;
//   the matrix stores keep their contents and are rewritten by every job.
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply_4x4
  import mm4_pkg::*;
#(
  parameter int DIM = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [DATA_W-1:0]    in_entry,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [DATA_W-1:0]         out_product_entry,
  output logic [OUT_IDX_W-1:0]             out_row,
  output logic [OUT_IDX_W-1:0]             out_col,
  output logic                             out_last
);

  localparam int IDX_W   = $clog2(DIM);
  localparam int ACC_W   = PROD_W + IDX_W;
  localparam int SAT_LSB = FRAC_W + DATA_W - 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  logic             busy_r;
  logic             ld_mat_r;
  logic [IDX_W-1:0] ld_row_r;
  logic [IDX_W-1:0] ld_col_r;
  logic             iss_active_r;
  logic [IDX_W-1:0] iss_row_r;
  logic [IDX_W-1:0] iss_col_r;
  logic             iss_last;

  logic             in_acc;
  logic             ld_done;
  logic             adv;
  logic [IDX_W-1:0] wr_idx;

  tok_t             tok_c [DIM+1];
  logic [ACC_W-1:0] acc_c [DIM+1];

  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_data_r;
  logic [OUT_IDX_W-1:0]      out_row_r;
  logic [OUT_IDX_W-1:0]      out_col_r;
  logic                      out_last_r;
  logic signed [DATA_W-1:0]  sat_nxt;
  logic [ACC_W-SAT_LSB-1:0]  acc_hi;

  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;
  assign ld_done  = in_acc && ld_mat_r && (ld_row_r == IDX_LAST) && (ld_col_r == IDX_LAST);
  assign adv      = !out_valid_r || out_ready;
  assign iss_last = (iss_row_r == IDX_LAST) && (iss_col_r == IDX_LAST);
  assign wr_idx   = ld_mat_r ? ld_row_r : ld_col_r;

  // load counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_mat_r <= 1'b0;
      ld_row_r <= '0;
      ld_col_r <= '0;
    end else if (in_acc) begin
      if (ld_col_r == IDX_LAST) begin
        ld_col_r <= '0;
        if (ld_row_r == IDX_LAST) begin
          ld_row_r <= '0;
          ld_mat_r <= !ld_mat_r;
        end else begin
          ld_row_r <= ld_row_r + 1'b1;
        end
      end else begin
        ld_col_r <= ld_col_r + 1'b1;
      end
    end
  end

  // token issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      iss_active_r <= 1'b0;
      iss_row_r    <= '0;
      iss_col_r    <= '0;
    end else begin
      if (ld_done) begin
        busy_r       <= 1'b1;
        iss_active_r <= 1'b1;
        iss_row_r    <= '0;
        iss_col_r    <= '0;
      end else if (iss_active_r && adv) begin
        if (iss_col_r == IDX_LAST) begin
          iss_col_r <= '0;
          iss_row_r <= iss_row_r + 1'b1;
        end else begin
          iss_col_r <= iss_col_r + 1'b1;
        end
        if (iss_last) begin
          iss_active_r <= 1'b0;
        end
      end
      if (out_valid_r && out_ready && out_last_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    tok_c[0].valid = iss_active_r;
    tok_c[0].row   = IDX_MAX_W'(iss_row_r);
    tok_c[0].col   = IDX_MAX_W'(iss_col_r);
    tok_c[0].last  = iss_last;
    acc_c[0]       = '0;
  end

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    mm4_cell #(
      .DIM(DIM)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .wr_l    (in_acc && !ld_mat_r && (ld_row_r == IDX_W'(k))),
      .wr_r    (in_acc && ld_mat_r && (ld_col_r == IDX_W'(k))),
      .wr_idx  (wr_idx),
      .wr_data (in_entry),
      .tok_in  (tok_c[k]),
      .acc_in  (acc_c[k]),
      .tok_out (tok_c[k+1]),
      .acc_out (acc_c[k+1])
    );
  end

  // floor shift by FRAC_W and saturate
  always_comb begin
    acc_hi = acc_c[DIM][ACC_W-1:SAT_LSB];
    if ((&acc_hi) || !(|acc_hi)) begin
      sat_nxt = acc_c[DIM][SAT_LSB:FRAC_W];
    end else if (acc_c[DIM][ACC_W-1]) begin
      sat_nxt = SAT_MIN;
    end else begin
      sat_nxt = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tok_c[DIM].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= sat_nxt;
      out_row_r  <= tok_c[DIM].row[OUT_IDX_W-1:0];
      out_col_r  <= tok_c[DIM].col[OUT_IDX_W-1:0];
      out_last_r <= tok_c[DIM].last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_entry = out_data_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_last          = out_last_r;

  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r)
    else $error("result item outside a job");

  a_no_load_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !iss_active_r && !tok_c[DIM].valid)
    else $error("load accepted while chain is active");

  a_done_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && out_last_r |=> !busy_r && !iss_active_r)
    else $error("job not closed after last item");

  a_start_issue: assert property (@(posedge clk) disable iff (!rst_n)
    ld_done |=> iss_active_r && busy_r && iss_row_r == '0 && iss_col_r == '0)
    else $error("issue did not start after final load");

endmodule
`default_nettype wire

// ===== rtl/mm4_cell.sv =====
// One MAC cell of the chain: holds one row of the first matrix and one column of the second.
`timescale 1ns / 1ps
`default_nettype none
module mm4_cell
  import mm4_pkg::*;
#(
  parameter int DIM = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            adv,
  input  wire logic                            wr_l,
  input  wire logic                            wr_r,
  input  wire logic [$clog2(DIM)-1:0]          wr_idx,
  input  wire logic [DATA_W-1:0]               wr_data,
  input  wire tok_t                            tok_in,
  input  wire logic [PROD_W+$clog2(DIM)-1:0]   acc_in,
  output tok_t                                 tok_out,
  output logic [PROD_W+$clog2(DIM)-1:0]        acc_out
);

  localparam int IDX_W = $clog2(DIM);
  localparam int ACC_W = PROD_W + IDX_W;

  logic [DATA_W-1:0] l_mem_r [DIM];
  logic [DATA_W-1:0] r_mem_r [DIM];

  tok_t                     tok1_r;
  tok_t                     tok2_r;
  logic [ACC_W-1:0]         acc1_r;
  logic [ACC_W-1:0]         acc2_r;
  logic signed [PROD_W-1:0] prod1_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [ACC_W-1:0]         acc2_nxt;

  always_ff @(posedge clk) begin
    if (wr_l) begin
      l_mem_r[wr_idx] <= wr_data;
    end
    if (wr_r) begin
      r_mem_r[wr_idx] <= wr_data;
    end
  end

  always_comb begin
    prod_nxt = $signed(r_mem_r[tok_in.row[IDX_W-1:0]]) *
               $signed(l_mem_r[tok_in.col[IDX_W-1:0]]);
    acc2_nxt = acc1_r + {{(ACC_W-PROD_W){prod1_r[PROD_W-1]}}, prod1_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r <= '0;
      tok2_r <= '0;
    end else if (adv) begin
      tok1_r <= tok_in;
      tok2_r <= tok1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc1_r  <= acc_in;
      prod1_r <= prod_nxt;
      acc2_r  <= acc2_nxt;
    end
  end

  assign tok_out = tok2_r;
  assign acc_out = acc2_r;

endmodule
`default_nettype wire
